[design/udivinv_pkg.sv]
package udivinv_pkg;

  localparam int unsigned WordBits = 64;
  localparam int unsigned HalfBits = WordBits / 2;

  typedef logic [WordBits-1:0] word_t;
  typedef logic [HalfBits-1:0] half_t;

  // Dividend of the reciprocal seed, (2^19 - 3*2^8), divided by the top nine divisor bits.
  localparam int unsigned SeedBits  = 19;
  localparam logic [SeedBits-1:0] SeedNum = 19'd523520;
  localparam int unsigned SeedSteps = SeedBits;

  localparam word_t DivisorReset = {1'b1, {(WordBits-1){1'b0}}};

  typedef enum logic [3:0] {
    RS_LOAD,
    RS_SEED,
    RS_V0SQ,
    RS_V1,
    RS_X,
    RS_V2,
    RS_E,
    RS_V3,
    RS_CHK,
    RS_FIN,
    RS_IDLE
  } recip_state_e;

  typedef struct packed {
    logic  ready;
    word_t value;
  } recip_t;

endpackage

[design/udivinv_req_if.sv]
interface udivinv_req_if;
  logic                 valid;
  logic                 ready;
  udivinv_pkg::word_t   num_high;
  udivinv_pkg::word_t   num_low;

  modport source(output valid, output num_high, output num_low, input ready);
  modport sink(input valid, input num_high, input num_low, output ready);
endinterface

[design/udivinv_rsp_if.sv]
interface udivinv_rsp_if;
  logic                 valid;
  logic                 ready;
  udivinv_pkg::word_t   quotient;
  udivinv_pkg::word_t   remainder;
  logic                 overflow;

  modport source(output valid, output quotient, output remainder, output overflow,
                 input ready);
  modport sink(input valid, input quotient, input remainder, input overflow,
               output ready);
endinterface

[design/udivinv_recip.sv]
module udivinv_recip (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  udivinv_pkg::word_t    divisor_i,
  output udivinv_pkg::recip_t   recip_o
);

  udivinv_pkg::recip_state_e state_q, state_d;

  logic [udivinv_pkg::SeedBits-1:0] seed_q;
  logic [8:0]                       rem_q;
  logic [4:0]                       cnt_q;
  logic [10:0]                      v0_q;
  logic [2:0]                       mcnt_q;
  logic [1:0]                       ppsh_q;
  logic [2*udivinv_pkg::WordBits-1:0] acc_q;
  logic [2*udivinv_pkg::WordBits-1:0] acc_sum;
  udivinv_pkg::word_t pp_q, pp_d;
  udivinv_pkg::word_t t_q, v1_q, v2_q, v3_q, hi_q, lo_q, recip_q;
  udivinv_pkg::word_t op_a, op_b, d40, d63;
  udivinv_pkg::half_t a_half, b_half;
  logic [8:0]  d9;
  logic [9:0]  rem_sh;
  logic        ge;
  logic [8:0]  rem_nx;
  logic        is_mul;
  logic        mul_last;
  logic        seed_last;
  logic [udivinv_pkg::WordBits:0] lo_sum;

  assign d9  = divisor_i[63] ? divisor_i[63:55] : 9'd256;
  assign d40 = {24'b0, divisor_i[63:24]} + 64'd1;
  assign d63 = {1'b0, divisor_i[63:1]} + {63'b0, divisor_i[0]};

  assign rem_sh    = {rem_q, seed_q[udivinv_pkg::SeedBits-1]};
  assign ge        = rem_sh >= {1'b0, d9};
  assign rem_nx    = ge ? 9'(rem_sh - {1'b0, d9}) : rem_sh[8:0];
  assign seed_last = cnt_q == 5'(udivinv_pkg::SeedSteps - 1);

  assign is_mul = state_q inside {udivinv_pkg::RS_V0SQ, udivinv_pkg::RS_V1, udivinv_pkg::RS_X,
                                  udivinv_pkg::RS_V2, udivinv_pkg::RS_E, udivinv_pkg::RS_V3,
                                  udivinv_pkg::RS_CHK};
  assign mul_last = mcnt_q == 3'd4;

  always_comb begin
    case (state_q)
      udivinv_pkg::RS_V0SQ: begin
        op_a = {53'b0, v0_q};
        op_b = {53'b0, v0_q};
      end
      udivinv_pkg::RS_V1: begin
        op_a = t_q;
        op_b = d40;
      end
      udivinv_pkg::RS_X: begin
        op_a = v1_q;
        op_b = d40;
      end
      udivinv_pkg::RS_V2: begin
        op_a = v1_q;
        op_b = t_q;
      end
      udivinv_pkg::RS_E: begin
        op_a = v2_q;
        op_b = d63;
      end
      udivinv_pkg::RS_V3: begin
        op_a = t_q;
        op_b = v2_q;
      end
      udivinv_pkg::RS_CHK: begin
        op_a = v3_q;
        op_b = divisor_i;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign a_half  = mcnt_q[0] ? op_a[63:32] : op_a[31:0];
  assign b_half  = mcnt_q[1] ? op_b[63:32] : op_b[31:0];
  assign pp_d    = {32'b0, a_half} * {32'b0, b_half};
  assign acc_sum = acc_q + ({64'b0, pp_q} << {ppsh_q, 5'b0});
  assign lo_sum  = {1'b0, lo_q} + {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= udivinv_pkg::RS_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      udivinv_pkg::RS_LOAD: state_d = udivinv_pkg::RS_SEED;
      udivinv_pkg::RS_SEED: if (seed_last) state_d = udivinv_pkg::RS_V0SQ;
      udivinv_pkg::RS_V0SQ: if (mul_last) state_d = udivinv_pkg::RS_V1;
      udivinv_pkg::RS_V1:   if (mul_last) state_d = udivinv_pkg::RS_X;
      udivinv_pkg::RS_X:    if (mul_last) state_d = udivinv_pkg::RS_V2;
      udivinv_pkg::RS_V2:   if (mul_last) state_d = udivinv_pkg::RS_E;
      udivinv_pkg::RS_E:    if (mul_last) state_d = udivinv_pkg::RS_V3;
      udivinv_pkg::RS_V3:   if (mul_last) state_d = udivinv_pkg::RS_CHK;
      udivinv_pkg::RS_CHK:  if (mul_last) state_d = udivinv_pkg::RS_FIN;
      udivinv_pkg::RS_FIN:  state_d = udivinv_pkg::RS_IDLE;
      udivinv_pkg::RS_IDLE: state_d = udivinv_pkg::RS_IDLE;
      default:              state_d = udivinv_pkg::RS_LOAD;
    endcase
    if (cfg_we_i) begin
      state_d = udivinv_pkg::RS_LOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcnt_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (is_mul && !mul_last && !cfg_we_i) begin
        mcnt_q <= mcnt_q + 3'd1;
      end else begin
        mcnt_q <= '0;
      end
      if (state_q == udivinv_pkg::RS_SEED) begin
        cnt_q <= cnt_q + 5'd1;
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pp_q   <= pp_d;
    ppsh_q <= {1'b0, mcnt_q[0]} + {1'b0, mcnt_q[1]};
    acc_q  <= (mcnt_q == 3'd0) ? '0 : acc_sum;
    case (state_q)
      udivinv_pkg::RS_LOAD: begin
        seed_q <= udivinv_pkg::SeedNum;
        rem_q  <= '0;
      end
      udivinv_pkg::RS_SEED: begin
        seed_q <= {seed_q[udivinv_pkg::SeedBits-2:0], ge};
        rem_q  <= rem_nx;
        if (seed_last) begin
          v0_q <= {seed_q[9:0], ge};
        end
      end
      udivinv_pkg::RS_V0SQ: if (mul_last) t_q <= acc_sum[63:0];
      udivinv_pkg::RS_V1: if (mul_last) begin
        v1_q <= ({53'b0, v0_q} << 11) - (acc_sum[63:0] >> 40) - 64'd1;
      end
      udivinv_pkg::RS_X: if (mul_last) t_q <= (64'd1 << 60) - acc_sum[63:0];
      udivinv_pkg::RS_V2: if (mul_last) begin
        v2_q <= (v1_q << 13) + (acc_sum[63:0] >> 47);
      end
      udivinv_pkg::RS_E: if (mul_last) begin
        t_q <= ({1'b0, v2_q[63:1]} & {64{divisor_i[0]}}) - acc_sum[63:0];
      end
      udivinv_pkg::RS_V3: if (mul_last) begin
        v3_q <= (v2_q << 31) + {1'b0, acc_sum[127:65]};
      end
      udivinv_pkg::RS_CHK: if (mul_last) begin
        hi_q <= acc_sum[127:64];
        lo_q <= acc_sum[63:0];
      end
      udivinv_pkg::RS_FIN: begin
        recip_q <= v3_q - (hi_q + divisor_i + {63'b0, lo_sum[64]});
      end
      default: begin
      end
    endcase
  end

  assign recip_o.ready = state_q == udivinv_pkg::RS_IDLE;
  assign recip_o.value = recip_q;

endmodule

[design/udiv_128by64_invariant_divisor.sv]
// An accepted request passes through pipeline registers p1 to p7, and p7 drives the result.
// Throughput: one request per cycle while neither the output nor the reciprocal unit stalls it,
// set by the seven-stage multiply pipeline. After reset and after every divisor write the
// reciprocal unit runs its 19 seed division steps and seven multiplies, and no request is taken.
// Reset is asynchronous and active low; it clears all valid bits and sets the divisor to 2^63.
module udiv_128by64_invariant_divisor (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  udivinv_pkg::word_t    cfg_wdata_i,
  udivinv_req_if.sink           req_i,
  udivinv_rsp_if.source         rsp_o
);

  udivinv_pkg::word_t  divisor_q;
  udivinv_pkg::recip_t recip;
  udivinv_pkg::word_t  v;

  logic [7:1] vld_q;
  logic [8:1] en;
  logic       accept;

  udivinv_pkg::word_t p1_u1_q, p1_u0_q, p1_pp00_q, p1_pp01_q, p1_pp10_q, p1_pp11_q;
  logic               p1_ovf_q;
  udivinv_pkg::word_t p2_u1_q, p2_u0_q;
  logic [127:0]       p2_prod_q;
  logic               p2_ovf_q;
  udivinv_pkg::word_t p3_q1p_q, p3_q0_q, p3_u0_q;
  logic               p3_ovf_q;
  udivinv_pkg::word_t p4_mm00_q, p4_q1p_q, p4_q0_q, p4_u0_q;
  udivinv_pkg::half_t p4_mm01_q, p4_mm10_q;
  logic               p4_ovf_q;
  udivinv_pkg::word_t p5_r_q, p5_q1p_q, p5_q0_q;
  logic               p5_ovf_q;
  udivinv_pkg::word_t p6_q_q, p6_r_q;
  logic               p6_ovf_q;
  udivinv_pkg::word_t p7_q_q, p7_r_q;
  logic               p7_ovf_q;

  logic [64:0]        q0_sum;
  udivinv_pkg::word_t q1p;
  udivinv_pkg::word_t mm01_full, mm10_full;
  udivinv_pkg::word_t prod_lo;

  udivinv_recip u_recip (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .divisor_i (divisor_q),
    .recip_o   (recip)
  );

  assign v = recip.value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divisor_q <= udivinv_pkg::DivisorReset;
    end else if (cfg_we_i) begin
      divisor_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    en[8] = rsp_o.ready;
    for (int k = 7; k >= 1; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign req_i.ready = en[1] && recip.ready;
  assign accept      = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[1]) begin
        vld_q[1] <= accept;
      end
      for (int k = 2; k <= 7; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign q0_sum    = {1'b0, p2_prod_q[63:0]} + {1'b0, p2_u0_q};
  assign q1p       = p2_prod_q[127:64] + p2_u1_q + {63'b0, q0_sum[64]} + 64'd1;
  assign mm01_full = {32'b0, p3_q1p_q[31:0]} * {32'b0, divisor_q[63:32]};
  assign mm10_full = {32'b0, p3_q1p_q[63:32]} * {32'b0, divisor_q[31:0]};
  assign prod_lo   = p4_mm00_q + {32'(p4_mm01_q + p4_mm10_q), 32'b0};

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      p1_u1_q   <= req_i.num_high;
      p1_u0_q   <= req_i.num_low;
      p1_ovf_q  <= !divisor_q[63] || (req_i.num_high >= divisor_q);
      p1_pp00_q <= {32'b0, v[31:0]}  * {32'b0, req_i.num_high[31:0]};
      p1_pp01_q <= {32'b0, v[31:0]}  * {32'b0, req_i.num_high[63:32]};
      p1_pp10_q <= {32'b0, v[63:32]} * {32'b0, req_i.num_high[31:0]};
      p1_pp11_q <= {32'b0, v[63:32]} * {32'b0, req_i.num_high[63:32]};
    end
    if (en[2]) begin
      p2_u1_q   <= p1_u1_q;
      p2_u0_q   <= p1_u0_q;
      p2_ovf_q  <= p1_ovf_q;
      p2_prod_q <= {p1_pp11_q, p1_pp00_q} + {32'b0, p1_pp01_q, 32'b0}
                   + {32'b0, p1_pp10_q, 32'b0};
    end
    if (en[3]) begin
      p3_q1p_q <= q1p;
      p3_q0_q  <= q0_sum[63:0];
      p3_u0_q  <= p2_u0_q;
      p3_ovf_q <= p2_ovf_q;
    end
    if (en[4]) begin
      p4_mm00_q <= {32'b0, p3_q1p_q[31:0]} * {32'b0, divisor_q[31:0]};
      p4_mm01_q <= mm01_full[31:0];
      p4_mm10_q <= mm10_full[31:0];
      p4_q1p_q  <= p3_q1p_q;
      p4_q0_q   <= p3_q0_q;
      p4_u0_q   <= p3_u0_q;
      p4_ovf_q  <= p3_ovf_q;
    end
    if (en[5]) begin
      p5_r_q   <= p4_u0_q - prod_lo;
      p5_q1p_q <= p4_q1p_q;
      p5_q0_q  <= p4_q0_q;
      p5_ovf_q <= p4_ovf_q;
    end
    if (en[6]) begin
      if (p5_r_q > p5_q0_q) begin
        p6_q_q <= p5_q1p_q - 64'd1;
        p6_r_q <= p5_r_q + divisor_q;
      end else begin
        p6_q_q <= p5_q1p_q;
        p6_r_q <= p5_r_q;
      end
      p6_ovf_q <= p5_ovf_q;
    end
    if (en[7]) begin
      if (p6_ovf_q) begin
        p7_q_q <= '0;
        p7_r_q <= '0;
      end else if (p6_r_q >= divisor_q) begin
        p7_q_q <= p6_q_q + 64'd1;
        p7_r_q <= p6_r_q - divisor_q;
      end else begin
        p7_q_q <= p6_q_q;
        p7_r_q <= p6_r_q;
      end
      p7_ovf_q <= p6_ovf_q;
    end
  end

  assign rsp_o.valid     = vld_q[7];
  assign rsp_o.quotient  = p7_q_q;
  assign rsp_o.remainder = p7_r_q;
  assign rsp_o.overflow  = p7_ovf_q;

endmodule

[design/udivinv_chk.sv]
module udivinv_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input udivinv_pkg::word_t cfg_wdata_i,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input udivinv_pkg::word_t quotient,
  input udivinv_pkg::word_t remainder,
  input logic               overflow
);

  udivinv_pkg::word_t div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= udivinv_pkg::DivisorReset;
    end else if (cfg_we_i) begin
      div_q <= cfg_wdata_i;
    end
  end

  // A stalled result must hold until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(quotient) && $stable(remainder)
                                && $stable(overflow))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && overflow |-> quotient == '0 && remainder == '0)
    else $error("overflow result is not zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !overflow |-> div_q[63] && remainder < div_q)
    else $error("remainder not below divisor");

  // The reciprocal is recomputed after a divisor write, so requests must wait.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !req_ready)
    else $error("request taken while reciprocal is stale");

endmodule

bind udiv_128by64_invariant_divisor udivinv_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_wdata_i (cfg_wdata_i),
  .req_ready   (req_i.ready),
  .rsp_valid   (rsp_o.valid),
  .rsp_ready   (rsp_o.ready),
  .quotient    (rsp_o.quotient),
  .remainder   (rsp_o.remainder),
  .overflow    (rsp_o.overflow)
);

[verif/tb_udiv_128by64_invariant_divisor.sv]
`timescale 1ns / 1ps

module tb_udiv_128by64_invariant_divisor;

  typedef struct packed {
    udivinv_pkg::word_t quotient;
    udivinv_pkg::word_t remainder;
    logic               overflow;
  } division_t;

  typedef struct packed {
    udivinv_pkg::word_t divisor;
    udivinv_pkg::word_t num_high;
    udivinv_pkg::word_t num_low;
    logic               known;
    udivinv_pkg::word_t quotient;
    udivinv_pkg::word_t remainder;
    logic               overflow;
  } division_case_t;

  localparam udivinv_pkg::word_t Ones = '1;
  localparam udivinv_pkg::word_t Half = udivinv_pkg::DivisorReset;
  localparam udivinv_pkg::word_t MaxBelow = Half - 64'd1;
  localparam udivinv_pkg::word_t HalfPlus = Half + 64'd1;
  localparam udivinv_pkg::word_t ThreeQ = 64'hC000_0000_0000_0000;
  localparam int unsigned DirectedCount = 20;
  localparam int unsigned RandomPhases = 8;
  localparam int unsigned PhaseItems = 75;
  localparam int unsigned DrainCycles = 20;

  // Rows sharing a divisor are kept together so that each setting is written at most once.
  localparam division_case_t DirectedCases [DirectedCount] = '{
    '{Half, 64'd0, 64'd0, 1'b1, 64'd0, 64'd0, 1'b0},
    '{Half, 64'd0, Ones, 1'b1, 64'd1, MaxBelow, 1'b0},
    '{Half, MaxBelow, Ones, 1'b1, Ones, MaxBelow, 1'b0},
    '{Half, Half, 64'd0, 1'b1, 64'd0, 64'd0, 1'b1},
    '{Half, Ones, Ones, 1'b1, 64'd0, 64'd0, 1'b1},
    '{Half, 64'h1234_5678_9ABC_DEF0, 64'h0FED_CBA9_8765_4321, 1'b0, 64'd0, 64'd0, 1'b0},
    '{Half, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'd0, 64'd0, 1'b0},
    '{Ones, 64'd0, 64'd0, 1'b1, 64'd0, 64'd0, 1'b0},
    '{Ones, 64'd0, Ones, 1'b1, 64'd1, 64'd0, 1'b0},
    '{Ones, Ones - 64'd1, Ones, 1'b1, Ones, Ones - 64'd1, 1'b0},
    '{Ones, Ones, 64'd0, 1'b1, 64'd0, 64'd0, 1'b1},
    '{Ones, Ones - 64'd1, 64'd0, 1'b0, 64'd0, 64'd0, 1'b0},
    '{Ones, 64'd1, 64'd0, 1'b1, 64'd1, 64'd1, 1'b0},
    '{HalfPlus, 64'd0, Ones, 1'b0, 64'd0, 64'd0, 1'b0},
    '{HalfPlus, Half, Ones, 1'b0, 64'd0, 64'd0, 1'b0},
    '{HalfPlus, HalfPlus, 64'd0, 1'b1, 64'd0, 64'd0, 1'b1},
    '{ThreeQ, ThreeQ - 64'd1, Ones, 1'b0, 64'd0, 64'd0, 1'b0},
    '{ThreeQ, 64'd0, ThreeQ, 1'b1, 64'd1, 64'd0, 1'b0},
    '{ThreeQ, 64'h8000_0000_FFFF_FFFF, 64'h7FFF_FFFF_0000_0000, 1'b0, 64'd0, 64'd0, 1'b0},
    '{64'hF0F0_F0F0_F0F0_F0F0, 64'h0F0F_0F0F_0F0F_0F0F, 64'hF0F0_F0F0_F0F0_F0F0, 1'b0,
      64'd0, 64'd0, 1'b0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  udivinv_pkg::word_t cfg_wdata;

  udivinv_req_if req_if();
  udivinv_rsp_if rsp_if();

  udiv_128by64_invariant_divisor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  udivinv_pkg::word_t divisor_reg = udivinv_pkg::DivisorReset;
  udivinv_pkg::word_t inverse;
  division_t pending_q[$];
  int unsigned errors = 0;
  int unsigned checked = 0;
  int unsigned overflows = 0;
  int unsigned divisor_writes = 0;
  bit calm = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [127:0] wide_product(udivinv_pkg::word_t a, udivinv_pkg::word_t b);
    return {64'd0, a} * {64'd0, b};
  endfunction

  function automatic udivinv_pkg::word_t inverse_of(udivinv_pkg::word_t d);
    udivinv_pkg::word_t dlsb, d9, d40, d63, v0, v1, v2, v3, e;
    logic [127:0] p;
    logic [64:0] s;
    dlsb = {63'd0, d[0]};
    d9 = d >> 55;
    d40 = (d >> 24) + 64'd1;
    d63 = (d >> 1) + dlsb;
    if (d9 < 64'd256) begin
      d9 = 64'd256;
    end
    v0 = 64'd523520 / d9;
    v1 = (v0 << 11) - ((v0 * v0 * d40) >> 40) - 64'd1;
    v2 = (v1 << 13) + ((v1 * ((64'd1 << 60) - v1 * d40)) >> 47);
    e = (v2 >> 1) * dlsb - v2 * d63;
    p = wide_product(e, v2);
    v3 = (v2 << 31) + (p[127:64] >> 1);
    p = wide_product(v3, d);
    s = {1'b0, p[63:0]} + {1'b0, d};
    return v3 - (p[127:64] + d + {63'd0, s[64]});
  endfunction

  function automatic division_t predict_division(udivinv_pkg::word_t u1, udivinv_pkg::word_t u0);
    division_t res;
    logic [127:0] p;
    logic [64:0] s;
    udivinv_pkg::word_t q0, q1, r;
    res = '0;
    if (!divisor_reg[udivinv_pkg::WordBits-1] || u1 >= divisor_reg) begin
      res.overflow = 1'b1;
      return res;
    end
    p = wide_product(inverse, u1);
    s = {1'b0, p[63:0]} + {1'b0, u0};
    q0 = s[63:0];
    q1 = p[127:64] + u1 + {63'd0, s[64]} + 64'd1;
    r = u0 - q1 * divisor_reg;
    if (r > q0) begin
      q1 = q1 - 64'd1;
      r = r + divisor_reg;
    end
    if (r >= divisor_reg) begin
      q1 = q1 + 64'd1;
      r = r - divisor_reg;
    end
    res.quotient = q1;
    res.remainder = r;
    return res;
  endfunction

  function automatic udivinv_pkg::word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 60) begin
      return 0;
    end
    if (r < 93) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(40, 8);
  endfunction

  task automatic send_division(input udivinv_pkg::word_t hi, input udivinv_pkg::word_t lo,
                               input bit known, input division_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.num_high <= hi;
    req_if.num_low <= lo;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
    pending_q.push_back(known ? want : predict_division(hi, lo));
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_divisor(input udivinv_pkg::word_t d);
    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    divisor_reg = d;
    inverse = inverse_of(d);
    divisor_writes++;
  endtask

  initial begin : result_sink
    int stall;
    division_t want;
    stall = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        if (pending_q.size() == 0) begin
          $display("%0t unexpected result: quotient %h remainder %h overflow %b", $time,
                   rsp_if.quotient, rsp_if.remainder, rsp_if.overflow);
          errors++;
        end else begin
          want = pending_q.pop_front();
          checked++;
          if (want.overflow) begin
            overflows++;
          end
          if (rsp_if.quotient !== want.quotient) begin
            $display("%0t quotient mismatch: expected %h, got %h", $time, want.quotient,
                     rsp_if.quotient);
            errors++;
          end
          if (rsp_if.remainder !== want.remainder) begin
            $display("%0t remainder mismatch: expected %h, got %h", $time, want.remainder,
                     rsp_if.remainder);
            errors++;
          end
          if (rsp_if.overflow !== want.overflow) begin
            $display("%0t overflow mismatch: expected %b, got %b", $time, want.overflow,
                     rsp_if.overflow);
            errors++;
          end
        end
      end
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        stall--;
      end else begin
        rsp_if.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin : stimulus
    division_case_t row;
    udivinv_pkg::word_t d, hi, lo;
    int sel;
    int unsigned n;
    rst_ni <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    req_if.valid <= 1'b0;
    req_if.num_high <= '0;
    req_if.num_low <= '0;
    inverse = inverse_of(divisor_reg);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DirectedCount; i++) begin
      row = DirectedCases[i];
      if (row.divisor != divisor_reg) begin
        set_divisor(row.divisor);
      end
      send_division(row.num_high, row.num_low, row.known,
                    '{row.quotient, row.remainder, row.overflow});
    end

    n = 0;
    for (int ph = 0; ph < RandomPhases; ph++) begin
      case (ph)
        0: d = Ones;
        1: d = udivinv_pkg::DivisorReset;
        2: d = HalfPlus;
        default: d = rand_word() | udivinv_pkg::DivisorReset;
      endcase
      set_divisor(d);
      for (int i = 0; i < PhaseItems; i++) begin
        if (n % 32 == 0) begin
          calm = ($urandom_range(3) == 0);
        end
        if (n % 97 == 50) begin
          drain_results();
        end
        sel = $urandom_range(99);
        lo = rand_word();
        if (sel < 4) begin
          hi = divisor_reg;
        end else if (sel < 10) begin
          hi = divisor_reg | rand_word();
        end else if (sel < 15) begin
          hi = divisor_reg - 64'd1;
        end else if (sel < 20) begin
          hi = {32'd0, $urandom} >> $urandom_range(31);
        end else begin
          hi = rand_word() % divisor_reg;
        end
        if ($urandom_range(9) == 0) begin
          lo = $urandom_range(1) ? Ones : '0;
        end
        send_division(hi, lo, 1'b0, '0);
        n++;
      end
    end

    calm = 1'b0;
    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Checked %0d divisions, %0d of them overflowing, across %0d divisor writes.",
             checked, overflows, divisor_writes);
    $display("Random numerators ran against %0d divisors including both extremes.",
             RandomPhases);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Timed out with %0d results outstanding.", pending_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[sim.f]
design/udivinv_pkg.sv
design/udivinv_req_if.sv
design/udivinv_rsp_if.sv
design/udivinv_recip.sv
design/udiv_128by64_invariant_divisor.sv
design/udivinv_chk.sv
verif/tb_udiv_128by64_invariant_divisor.sv
